// ===== hdl/ppt_pkg.sv =====
// Shared constants, types and helpers of the pulse period tracker.
`default_nettype none
package ppt_pkg;

   // Sample ring geometry.
   localparam int RING_DEPTH = 96;
   localparam int RING_AW    = $clog2(RING_DEPTH);

   // Configuration port geometry.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RATE_MIN       = 3'd0,
      CSR_RATE_MAX       = 3'd1,
      CSR_TARGET_PERIOD  = 3'd2,
      CSR_DEBOUNCE_TICKS = 3'd3,
      CSR_MODE_LIMIT     = 3'd4,
      CSR_TRIGGER_STEP   = 3'd5
   } csr_index_type;

   // Reset values of configuration and state.
   localparam logic [7:0]  RATE_MIN_RST       = 8'd52;
   localparam logic [7:0]  RATE_MAX_RST       = 8'd200;
   localparam logic [15:0] TARGET_PERIOD_RST  = 16'd96;
   localparam logic [7:0]  DEBOUNCE_TICKS_RST = 8'd12;
   localparam logic [4:0]  MODE_LIMIT_RST     = 5'd25;
   localparam logic [3:0]  TRIGGER_STEP_RST   = 4'd10;
   localparam logic [15:0] PERIOD_RST         = 16'd300;
   localparam logic [7:0]  DIVIDER_RST        = 8'd52;
   localparam logic [4:0]  MODE_RST           = 5'd5;

   // Status fields that travel with every result word.
   typedef struct packed {
      logic [7:0]  trigger_level;
      logic [4:0]  mode_value;
      logic [7:0]  rate_divider;
      logic [6:0]  crossing_position;
      logic [15:0] period;
      logic        crossed;
   } status_type;

   // Trigger level is mode times step, saturated at 255.
   function automatic logic [7:0] trigger_level_of(input logic [4:0] mode,
                                                   input logic [3:0] step);
      logic [8:0] prod;
      prod = 9'(mode) * 9'(step);
      return prod[8] ? 8'hFF : prod[7:0];
   endfunction

endpackage
`default_nettype wire

// ===== hdl/ppt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module ppt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 96,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds while rd_en is low.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/pulse_period_tracker.sv =====
// Top level of the pulse period tracker: sample ring, crossing detector and mode control.
//
// The block takes one word per clock unless stalled. A tick word (tuser low) stores its sample in a
// 96-entry ring held in a synchronous RAM, counts ticks, detects falling crossings of the
// trigger level, steps the sample-rate divider toward the target period and debounces the
// mode button; a read word (tuser high) fetches one ring entry. Every word's result word is
// presented through the read stage and then the output register: the accepting edge starts
// the ring RAM read, and the output register loads when the read stage advances. A word can
// enter every cycle; the output register and the read stage only stall the input when the
// result side holds tready low. The ring reads as all zero after reset through one valid
// flip-flop per entry, so there is no clearing pass.
`default_nettype none
module pulse_period_tracker
   import ppt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [15:0]           req_tdata,  // sample[7:0], button_level[8], read_index[15:9]
   input  wire logic                  req_tuser,  // cmd[0]
   // Response channel.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // read_data[7:0], crossed[8], period[24:9], crossing_position[31:25],
   // rate_divider[39:32], mode_value[44:40], trigger_level[52:45], zero fill [55:53]
   output logic [55:0]                rsp_tdata,
   // Configuration write port.
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers.
   logic [7:0]  rate_min_ff, rate_max_ff, debounce_ff;
   logic [15:0] target_ff;
   logic [4:0]  mode_limit_ff;
   logic [3:0]  trig_step_ff;

   // Tracker state.
   logic [RING_AW-1:0]    wp_ff, wp_in;
   logic                  have_prev_ff, have_prev_in;
   logic [7:0]            prev_ff, prev_in;
   logic [15:0]           tick_ff, tick_in;
   logic [15:0]           period_ff, period_in;
   logic [RING_AW-1:0]    cross_pos_ff, cross_pos_in;
   logic [7:0]            divider_ff, divider_in;
   logic [4:0]            mode_ff, mode_in;
   logic [7:0]            press_ff, press_in;
   logic                  seen_ff, seen_in;
   logic [RING_DEPTH-1:0] ring_valid_ff, ring_valid_in;

   // Read stage and output register.
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_hit_ff, s1_hit_in;
   status_type s1_status_ff, s1_status_in;
   logic       rsp_valid_ff;
   logic [7:0] rsp_rdata_ff;
   status_type rsp_status_ff;

   // Request fields.
   logic       cmd_read;
   logic [7:0] in_sample;
   logic       in_button;
   logic [6:0] in_index;

   logic               req_fire, tick_fire, read_fire, s1_advance, in_range, crossed;
   logic [7:0]         trig_old;
   logic [15:0]        tick_inc;
   logic [5:0]         mode_next;
   logic [RING_AW-1:0] rd_addr;
   logic [7:0]         ram_rd_data;

   assign cmd_read  = req_tuser;
   assign in_sample = req_tdata[7:0];
   assign in_button = req_tdata[8];
   assign in_index  = req_tdata[15:9];

   // Handshake: the read stage moves on whenever the output register is free or being taken.
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_fire   = req_tvalid && req_tready;
   assign tick_fire  = req_fire && !cmd_read;
   assign read_fire  = req_fire && cmd_read;

   assign in_range = 32'(in_index) < RING_DEPTH;
   assign rd_addr  = RING_AW'(in_index);

   // Sample ring storage.
   ppt_ram #(
      .WIDTH (8),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (tick_fire),
      .wr_addr (wp_ff),
      .wr_data (in_sample),
      .rd_en   (read_fire && in_range),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // Tick processing: crossing test, period, divider, write position and button.
   always_comb begin
      wp_in         = wp_ff;
      have_prev_in  = have_prev_ff;
      prev_in       = prev_ff;
      tick_in       = tick_ff;
      period_in     = period_ff;
      cross_pos_in  = cross_pos_ff;
      divider_in    = divider_ff;
      mode_in       = mode_ff;
      press_in      = press_ff;
      seen_in       = seen_ff;
      ring_valid_in = ring_valid_ff;
      crossed       = 1'b0;
      trig_old      = trigger_level_of(mode_ff, trig_step_ff);
      tick_inc      = (tick_ff == 16'hFFFF) ? tick_ff : tick_ff + 16'd1;
      mode_next     = 6'(mode_ff) + 6'd1;

      if (tick_fire) begin
         ring_valid_in[wp_ff] = 1'b1;
         tick_in = tick_inc;
         if (have_prev_ff && prev_ff > trig_old && in_sample <= trig_old) begin
            crossed      = 1'b1;
            period_in    = tick_inc;
            tick_in      = 16'd0;
            cross_pos_in = wp_ff;
            if (tick_inc > target_ff && divider_ff < rate_max_ff) begin
               divider_in = divider_ff + 8'd1;
            end else if (tick_inc < target_ff && divider_ff > rate_min_ff) begin
               divider_in = divider_ff - 8'd1;
            end
         end
         prev_in      = in_sample;
         have_prev_in = 1'b1;
         wp_in = (wp_ff == RING_AW'(RING_DEPTH - 1)) ? '0 : wp_ff + RING_AW'(1);

         // Debounced button steps the mode once per press.
         if (in_button) begin
            if (press_ff > debounce_ff) begin
               if (!seen_ff) begin
                  seen_in = 1'b1;
                  mode_in = (mode_next > 6'(mode_limit_ff)) ? 5'd0 : mode_next[4:0];
               end
            end else if (press_ff != 8'hFF) begin
               press_in = press_ff + 8'd1;
            end
         end else begin
            seen_in  = 1'b0;
            press_in = 8'd0;
         end
      end
   end

   // Read stage contents: status after this word, and whether the ring entry was written.
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_hit_in    = s1_hit_ff;
      s1_status_in = s1_status_ff;
      if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_hit_in   = 1'b0;
         if (read_fire && in_range) begin
            s1_hit_in = ring_valid_ff[rd_addr];
         end
         s1_status_in.crossed           = crossed;
         s1_status_in.period            = period_in;
         s1_status_in.crossing_position = 7'(cross_pos_in);
         s1_status_in.rate_divider      = divider_in;
         s1_status_in.mode_value        = mode_in;
         s1_status_in.trigger_level     = trigger_level_of(mode_in, trig_step_ff);
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_min_ff   <= RATE_MIN_RST;
         rate_max_ff   <= RATE_MAX_RST;
         target_ff     <= TARGET_PERIOD_RST;
         debounce_ff   <= DEBOUNCE_TICKS_RST;
         mode_limit_ff <= MODE_LIMIT_RST;
         trig_step_ff  <= TRIGGER_STEP_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RATE_MIN:       rate_min_ff   <= csr_wdata[7:0];
            CSR_RATE_MAX:       rate_max_ff   <= csr_wdata[7:0];
            CSR_TARGET_PERIOD:  target_ff     <= csr_wdata;
            CSR_DEBOUNCE_TICKS: debounce_ff   <= csr_wdata[7:0];
            CSR_MODE_LIMIT:     mode_limit_ff <= csr_wdata[4:0];
            CSR_TRIGGER_STEP:   trig_step_ff  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Tracker state and pipeline control.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff         <= '0;
         have_prev_ff  <= 1'b0;
         prev_ff       <= 8'd0;
         tick_ff       <= 16'd0;
         period_ff     <= PERIOD_RST;
         cross_pos_ff  <= '0;
         divider_ff    <= DIVIDER_RST;
         mode_ff       <= MODE_RST;
         press_ff      <= 8'd0;
         seen_ff       <= 1'b0;
         ring_valid_ff <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         wp_ff         <= wp_in;
         have_prev_ff  <= have_prev_in;
         prev_ff       <= prev_in;
         tick_ff       <= tick_in;
         period_ff     <= period_in;
         cross_pos_ff  <= cross_pos_in;
         divider_ff    <= divider_in;
         mode_ff       <= mode_in;
         press_ff      <= press_in;
         seen_ff       <= seen_in;
         ring_valid_ff <= ring_valid_in;
         s1_valid_ff   <= s1_valid_in;
         if (s1_advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers of the read stage and the output register.
   always_ff @(posedge clock) begin
      s1_hit_ff    <= s1_hit_in;
      s1_status_ff <= s1_status_in;
      if (s1_advance) begin
         rsp_rdata_ff  <= s1_hit_ff ? ram_rd_data : 8'd0;
         rsp_status_ff <= s1_status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_status_ff, rsp_rdata_ff};

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench of the pulse period tracker with a built-in predictor.
`timescale 1ns / 1ps
module tb_top;
   import ppt_pkg::*;

   // Word kinds carried on req_tuser.
   typedef enum logic {
      CMD_TICK = 1'b0,
      CMD_READ = 1'b1
   } cmd_type;

   // One request word; the low 16 bits are laid out exactly as req_tdata.
   typedef struct packed {
      cmd_type    cmd;
      logic [6:0] read_index;
      logic       button_level;
      logic [7:0] sample;
   } request_type;

   // One result word; laid out exactly as rsp_tdata[52:0].
   typedef struct packed {
      status_type status;
      logic [7:0] read_data;
   } result_type;

   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int MAX_REPORTS  = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // sample[7:0], button_level[8], read_index[15:9]
   logic        req_tuser = 1'b0; // cmd[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // read_data[7:0], crossed[8], period[24:9], crossing_position[31:25],
   // rate_divider[39:32], mode_value[44:40], trigger_level[52:45], zero fill [55:53]
   logic [55:0] rsp_tdata;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   pulse_period_tracker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Words waiting to be sent and results predicted for accepted words.
   request_type queued_words[$];
   result_type  predicted_words[$];
   request_type offered_word;

   int unsigned mismatch_count = 0;
   int unsigned result_count = 0;
   int unsigned send_idle_pct = 25;
   int unsigned recv_idle_pct = 88;
   logic        hold_request = 1'b0;
   logic        hold_taken = 1'b0;
   int unsigned hold_left = 0;

   // Tracker copy: configuration.
   logic [7:0]  cfg_rate_min;
   logic [7:0]  cfg_rate_max;
   logic [15:0] cfg_target;
   logic [7:0]  cfg_debounce;
   logic [4:0]  cfg_mode_limit;
   logic [3:0]  cfg_trigger_step;

   // Tracker copy: state.
   logic [7:0]  ring [RING_DEPTH];
   logic [6:0]  wr_pos;
   logic        have_prev;
   logic [7:0]  prev_sample;
   logic [15:0] tick_count;
   logic [15:0] last_period;
   logic [6:0]  last_cross;
   logic [7:0]  divider;
   logic [4:0]  mode;
   logic [7:0]  press_ticks;
   logic        press_seen;

   // Random waveform generator state.
   logic        wave_high = 1'b0;
   int unsigned wave_left = 0;
   logic        button_now = 1'b0;
   int unsigned button_left = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   // Trigger level for a mode: mode times step, clipped to eight bits.
   function automatic logic [7:0] level_for(input logic [4:0] m);
      logic [8:0] prod;
      prod = {4'b0, m} * {5'b0, cfg_trigger_step};
      return (prod > 9'd255) ? 8'hFF : prod[7:0];
   endfunction

   // Advances the tracker copy by one accepted word and returns its result.
   function automatic result_type track_word(input request_type w);
      result_type r;
      logic [7:0] level;
      r = '0;
      if (w.cmd == CMD_READ) begin
         if (w.read_index < RING_DEPTH)
            r.read_data = ring[w.read_index];
      end else begin
         // The crossing uses the level of the mode held before this tick.
         level = level_for(mode);
         ring[wr_pos] = w.sample;
         if (tick_count != 16'hFFFF)
            tick_count = tick_count + 16'd1;
         if (have_prev && prev_sample > level && w.sample <= level) begin
            r.status.crossed = 1'b1;
            last_period = tick_count;
            tick_count = '0;
            last_cross = wr_pos;
            if (last_period > cfg_target && divider < cfg_rate_max)
               divider = divider + 8'd1;
            else if (last_period < cfg_target && divider > cfg_rate_min)
               divider = divider - 8'd1;
         end
         prev_sample = w.sample;
         have_prev = 1'b1;
         wr_pos = (wr_pos == RING_DEPTH - 1) ? '0 : wr_pos + 7'd1;

         // Debounced button: one mode step per press held long enough.
         if (w.button_level) begin
            if (press_ticks > cfg_debounce) begin
               if (!press_seen) begin
                  press_seen = 1'b1;
                  mode = (mode >= cfg_mode_limit) ? 5'd0 : mode + 5'd1;
               end
            end else if (press_ticks != 8'hFF) begin
               press_ticks = press_ticks + 8'd1;
            end
         end else begin
            press_seen = 1'b0;
            press_ticks = '0;
         end
      end
      r.status.period = last_period;
      r.status.crossing_position = last_cross;
      r.status.rate_divider = divider;
      r.status.mode_value = mode;
      r.status.trigger_level = level_for(mode);
      return r;
   endfunction

   function automatic void push_tick(input logic [7:0] sample, input logic button);
      request_type w;
      w = '0;
      w.cmd = CMD_TICK;
      w.sample = sample;
      w.button_level = button;
      queued_words.push_back(w);
   endfunction

   function automatic void push_read(input logic [6:0] index);
      request_type w;
      w = '0;
      w.cmd = CMD_READ;
      w.read_index = index;
      queued_words.push_back(w);
   endfunction

   // Mostly a square wave around typical trigger levels with held button presses,
   // with some raw samples and reads mixed in.
   function automatic request_type next_random_word();
      request_type w;
      int unsigned pick;
      pick = $urandom_range(99);
      w.sample = 8'($urandom);
      w.button_level = 1'($urandom);
      w.read_index = 7'($urandom);
      if (pick < 10) begin
         w.cmd = CMD_READ;
         w.read_index = (pick < 2) ? 7'($urandom_range(96, 127)) : 7'($urandom_range(0, 95));
         return w;
      end
      w.cmd = CMD_TICK;
      if (wave_left == 0) begin
         wave_high = ~wave_high;
         wave_left = $urandom_range(1, ($urandom_range(3) == 0) ? 120 : 20);
      end
      wave_left--;
      if (pick >= 22)
         w.sample = wave_high ? 8'($urandom_range(170, 255)) : 8'($urandom_range(0, 30));
      if (button_left == 0) begin
         button_now = ~button_now;
         button_left = $urandom_range(1, 30);
      end
      button_left--;
      w.button_level = button_now;
      return w;
   endfunction

   function automatic void push_random(input int unsigned count);
      repeat (count) queued_words.push_back(next_random_word());
   endfunction

   // Reports one failure and counts it.
   task automatic report_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("[%0t] ERROR: %s", $realtime, msg);
   endtask

   task automatic compare_field(input string name, input int unsigned got,
                                input int unsigned want);
      if (got != want)
         report_error($sformatf("result %0d: %s is %0d, expected %0d",
                                result_count, name, got, want));
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_RATE_MIN:       cfg_rate_min = value[7:0];
         CSR_RATE_MAX:       cfg_rate_max = value[7:0];
         CSR_TARGET_PERIOD:  cfg_target = value;
         CSR_DEBOUNCE_TICKS: cfg_debounce = value[7:0];
         CSR_MODE_LIMIT:     cfg_mode_limit = value[4:0];
         CSR_TRIGGER_STEP:   cfg_trigger_step = value[3:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic apply_settings(input logic [7:0] rmin, input logic [7:0] rmax,
                                 input logic [15:0] target, input logic [7:0] debounce,
                                 input logic [4:0] limit, input logic [3:0] step);
      write_reg(CSR_RATE_MIN, {8'd0, rmin});
      write_reg(CSR_RATE_MAX, {8'd0, rmax});
      write_reg(CSR_TARGET_PERIOD, target);
      write_reg(CSR_DEBOUNCE_TICKS, {8'd0, debounce});
      write_reg(CSR_MODE_LIMIT, {11'd0, limit});
      write_reg(CSR_TRIGGER_STEP, {12'd0, step});
      @(negedge clock);
   endtask

   // Waits until every queued word is sent and every result has come back.
   task automatic wait_drained();
      do @(negedge clock);
      while (queued_words.size() != 0 || predicted_words.size() != 0 || req_tvalid);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Driver: offers the next word once the current one is taken, idling at random.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            predicted_words.push_back(track_word(offered_word));
         if (!req_tvalid || req_tready) begin
            if (queued_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered_word = queued_words.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= offered_word[15:0];
               req_tuser <= offered_word.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here so the block backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_request && !hold_taken) begin
         hold_left <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: checks each accepted result word against the oldest prediction.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[52:0]);
            if (predicted_words.size() == 0) begin
               report_error($sformatf("unexpected result word %h", rsp_tdata));
            end else begin
               want = predicted_words.pop_front();
               compare_field("read_data", got.read_data, want.read_data);
               compare_field("crossed", got.status.crossed, want.status.crossed);
               compare_field("period", got.status.period, want.status.period);
               compare_field("crossing_position", got.status.crossing_position,
                             want.status.crossing_position);
               compare_field("rate_divider", got.status.rate_divider,
                             want.status.rate_divider);
               compare_field("mode_value", got.status.mode_value, want.status.mode_value);
               compare_field("trigger_level", got.status.trigger_level,
                             want.status.trigger_level);
            end
            result_count++;
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Run limit.
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

   // Stimulus phases.
   initial begin
      // Tracker copy after reset.
      cfg_rate_min = RATE_MIN_RST;
      cfg_rate_max = RATE_MAX_RST;
      cfg_target = TARGET_PERIOD_RST;
      cfg_debounce = DEBOUNCE_TICKS_RST;
      cfg_mode_limit = MODE_LIMIT_RST;
      cfg_trigger_step = TRIGGER_STEP_RST;
      foreach (ring[i]) ring[i] = '0;
      wr_pos = '0;
      have_prev = 1'b0;
      prev_sample = '0;
      tick_count = '0;
      last_period = PERIOD_RST;
      last_cross = '0;
      divider = DIVIDER_RST;
      mode = MODE_RST;
      press_ticks = '0;
      press_seen = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words at reset settings: cleared ring, reads past the end,
      // first tick without a previous sample, a crossing exactly at the level,
      // and a mode step on a crossing tick that must use the old level.
      push_read(7'd0);
      push_read(7'd127);
      push_read(7'd96);
      push_tick(8'd255, 1'b0);
      push_tick(8'd0, 1'b0);
      push_tick(8'd51, 1'b0);
      push_tick(8'd50, 1'b0);
      repeat (13) push_tick(8'd255, 1'b1);
      push_tick(8'd0, 1'b1);
      push_read(7'd95);
      push_read(7'd3);
      push_tick(8'd128, 1'b0);
      push_random(150);
      wait_drained();

      // Widest limits, shortest target, no debounce, largest mode and step.
      apply_settings(8'd0, 8'd255, 16'd1, 8'd0, 5'd31, 4'd15);
      push_random(100);
      wait_drained();

      // Inverted limits, longest target, a button that never registers, step zero.
      send_idle_pct = 88;
      recv_idle_pct = 25;
      apply_settings(8'd255, 8'd0, 16'd65535, 8'd255, 5'd0, 4'd0);
      push_random(100);
      wait_drained();

      // Narrow divider window around short periods.
      apply_settings(8'd40, 8'd60, 16'd20, 8'd3, 5'd7, 4'd6);
      push_random(100);
      wait_drained();

      // No idling; random settings, then a long receiver hold-off.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_settings(8'($urandom), 8'($urandom), 16'($urandom_range(1, 200)),
                     8'($urandom_range(0, 20)), 5'($urandom), 4'($urandom));
      push_random(100);
      wait_drained();
      push_random(150);
      hold_request = 1'b1;
      wait_drained();

      // A long run above a low level, then a drop.
      apply_settings(8'd10, 8'd250, 16'd1000, 8'd12, 5'd7, 4'd4);
      repeat (40) push_tick(8'($urandom_range(200, 255)), 1'b0);
      push_tick(8'd0, 1'b0);
      push_read(7'd0);
      push_read(7'd47);
      push_random(50);
      wait_drained();

      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
